[hw/rtl/gfba_pkg.sv]
// Package: shared types, codes and sizes for the grouped free block allocator.
`timescale 1ns / 1ps
`default_nettype none
package gfba_pkg;

  localparam int GROUP_SIZE = 64;
  localparam int SLOT_W     = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam int IDX_W      = 6;
  localparam int TOP_W      = 7;
  localparam int WORD_W     = 32;

  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic [IDX_W-1:0]         eidx_t;
  typedef logic signed [TOP_W-1:0]  top_t;
  typedef logic [WORD_W-1:0]        word_t;

  localparam top_t TOP_MAX   = top_t'(GROUP_SIZE - 1);
  localparam top_t TOP_EMPTY = top_t'(-1);
  localparam slot_t SLOT_LAST = slot_t'(GROUP_SIZE - 1);

  typedef enum logic [1:0] {
    ACT_ALLOC      = 2'd0,
    ACT_RECYCLE    = 2'd1,
    ACT_LOAD_ENTRY = 2'd2,
    ACT_LOAD_TOP   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    K_GRANTED  = 3'd0,
    K_NONE     = 3'd1,
    K_SPILL    = 3'd2,
    K_RECYCLED = 3'd3,
    K_ACCEPTED = 3'd4,
    K_REJECTED = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_SPILL
  } state_t;

  // request from the sequencer to the slot store
  typedef struct packed {
    logic  wr_en;
    slot_t wr_idx;
    word_t wr_data;
    slot_t rd_idx;
    logic  clear;
  } store_req_t;

endpackage
`default_nettype wire

[hw/rtl/gfba_ram.sv]
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module gfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/gfba_store.sv]
// Slot store: group RAM plus per-slot valid bits so unwritten slots read as zero.
`timescale 1ns / 1ps
`default_nettype none
module gfba_store (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gfba_pkg::store_req_t req,
  output gfba_pkg::word_t          rd_value
);

  logic [gfba_pkg::GROUP_SIZE-1:0] valid_r;
  logic [gfba_pkg::GROUP_SIZE-1:0] valid_nxt;
  gfba_pkg::slot_t                 rd_idx_r;
  gfba_pkg::word_t                 ram_q;

  gfba_ram #(
    .WIDTH(gfba_pkg::WORD_W),
    .DEPTH(gfba_pkg::GROUP_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (req.wr_en),
    .waddr (req.wr_idx),
    .wdata (req.wr_data),
    .raddr (req.rd_idx),
    .rdata (ram_q)
  );

  always_comb begin
    valid_nxt = req.clear ? '0 : valid_r;
    if (req.wr_en) begin
      valid_nxt[req.wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
    rd_idx_r <= req.rd_idx;
  end

  assign rd_value = valid_r[rd_idx_r] ? ram_q : '0;

endmodule
`default_nettype wire

[hw/rtl/grouped_free_block_allocator.sv]
// Top level: sequencer for the grouped free block list allocator.
//
// Usage: drive in_* and raise start; a word is taken at a clock edge with
// start high and busy low. Results come out one word per cycle on out_*,
// each marked by out_valid for exactly one cycle; out_last flags the final
// result of an item. The receiver cannot stall, so results are never held.
// Behaviour by item kind:
//   recycle, load, rejected, and allocate from an empty group: result in the
//   cycle after accept, next item accepted in the next cycle.
//   allocate from a nonempty group: the top slot is read from the group RAM
//   in ST_ALLOC, then the result is registered; no new item is taken in ST_ALLOC.
//   recycle into a full group: the single RAM read port walks the group,
//   one slot per cycle, giving GROUP_SIZE spill words; busy until the last
//   slot has been read.
// After a link grant (out_refill_needed) only load items are taken until a
// load group top word arrives; allocate and recycle answer rejected.
// Reset (synchronous, rst_n low) empties the group: all slots read as zero,
// top is -1, no refill pending. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module grouped_free_block_allocator (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             in_action,
  input  wire logic [31:0]            in_block_addr,
  input  wire logic [5:0]             in_entry_index,
  input  wire logic signed [6:0]      in_top_value,
  output logic                        out_valid,
  output logic [2:0]                  out_kind,
  output logic [31:0]                 out_address,
  output logic [5:0]                  out_spill_index,
  output logic [31:0]                 out_spill_value,
  output logic                        out_refill_needed,
  output logic                        out_last
);

  gfba_pkg::state_t     state_r, state_nxt;
  gfba_pkg::top_t       top_r, top_nxt;
  logic                 awaiting_r, awaiting_nxt;
  gfba_pkg::slot_t      idx_r, idx_nxt;
  gfba_pkg::word_t      spill_addr_r, spill_addr_nxt;

  logic                 out_valid_r, out_valid_nxt;
  gfba_pkg::kind_t      out_kind_r, out_kind_nxt;
  gfba_pkg::word_t      out_address_r, out_address_nxt;
  gfba_pkg::eidx_t      out_sidx_r, out_sidx_nxt;
  gfba_pkg::word_t      out_sval_r, out_sval_nxt;
  logic                 out_refill_r, out_refill_nxt;
  logic                 out_last_r, out_last_nxt;

  gfba_pkg::store_req_t req;
  gfba_pkg::word_t      rd_value;
  gfba_pkg::top_t       top_inc;
  gfba_pkg::top_t       top_sat;
  gfba_pkg::action_t    action;

  gfba_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .rd_value (rd_value)
  );

  assign action  = gfba_pkg::action_t'(in_action);
  assign top_inc = top_r + gfba_pkg::top_t'(1);

  always_comb begin
    if (in_top_value < gfba_pkg::TOP_EMPTY) begin
      top_sat = gfba_pkg::TOP_EMPTY;
    end else if (in_top_value > gfba_pkg::TOP_MAX) begin
      top_sat = gfba_pkg::TOP_MAX;
    end else begin
      top_sat = in_top_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gfba_pkg::ST_IDLE;
      top_r       <= gfba_pkg::TOP_EMPTY;
      awaiting_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      awaiting_r  <= awaiting_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r         <= idx_nxt;
    spill_addr_r  <= spill_addr_nxt;
    out_kind_r    <= out_kind_nxt;
    out_address_r <= out_address_nxt;
    out_sidx_r    <= out_sidx_nxt;
    out_sval_r    <= out_sval_nxt;
    out_refill_r  <= out_refill_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    top_nxt         = top_r;
    awaiting_nxt    = awaiting_r;
    idx_nxt         = idx_r;
    spill_addr_nxt  = spill_addr_r;

    out_valid_nxt   = 1'b0;
    out_kind_nxt    = gfba_pkg::K_REJECTED;
    out_address_nxt = '0;
    out_sidx_nxt    = '0;
    out_sval_nxt    = '0;
    out_refill_nxt  = 1'b0;
    out_last_nxt    = 1'b1;

    req.wr_en   = 1'b0;
    req.wr_idx  = top_inc[gfba_pkg::SLOT_W-1:0];
    req.wr_data = in_block_addr;
    req.clear   = 1'b0;
    req.rd_idx  = (action == gfba_pkg::ACT_RECYCLE) ? '0 : top_r[gfba_pkg::SLOT_W-1:0];

    case (state_r)
      gfba_pkg::ST_IDLE: begin
        if (start) begin
          case (action)
            gfba_pkg::ACT_ALLOC: begin
              if (awaiting_r) begin
                out_valid_nxt = 1'b1;
              end else if (top_r < 0) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = gfba_pkg::K_NONE;
              end else begin
                state_nxt = gfba_pkg::ST_ALLOC;
              end
            end
            gfba_pkg::ACT_RECYCLE: begin
              if (awaiting_r) begin
                out_valid_nxt = 1'b1;
              end else if (top_r >= gfba_pkg::TOP_MAX) begin
                state_nxt      = gfba_pkg::ST_SPILL;
                idx_nxt        = '0;
                spill_addr_nxt = in_block_addr;
              end else begin
                req.wr_en     = 1'b1;
                top_nxt       = top_inc;
                out_valid_nxt = 1'b1;
                out_kind_nxt  = gfba_pkg::K_RECYCLED;
              end
            end
            gfba_pkg::ACT_LOAD_ENTRY: begin
              out_valid_nxt = 1'b1;
              if (awaiting_r) begin
                out_kind_nxt = gfba_pkg::K_ACCEPTED;
                req.wr_idx   = in_entry_index[gfba_pkg::SLOT_W-1:0];
                req.wr_en    = ({1'b0, in_entry_index} <
                                gfba_pkg::TOP_W'(gfba_pkg::GROUP_SIZE));
              end
            end
            gfba_pkg::ACT_LOAD_TOP: begin
              out_valid_nxt = 1'b1;
              if (awaiting_r) begin
                out_kind_nxt = gfba_pkg::K_ACCEPTED;
                top_nxt      = top_sat;
                awaiting_nxt = 1'b0;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      gfba_pkg::ST_ALLOC: begin
        state_nxt     = gfba_pkg::ST_IDLE;
        out_valid_nxt = 1'b1;
        if (top_r == 0) begin
          if (rd_value == '0) begin
            out_kind_nxt = gfba_pkg::K_NONE;
          end else begin
            // only the link is left: hand it out and wait for the next group
            out_kind_nxt    = gfba_pkg::K_GRANTED;
            out_address_nxt = rd_value;
            out_refill_nxt  = 1'b1;
            top_nxt         = gfba_pkg::TOP_EMPTY;
            awaiting_nxt    = 1'b1;
          end
        end else begin
          out_kind_nxt    = gfba_pkg::K_GRANTED;
          out_address_nxt = rd_value;
          top_nxt         = top_r - gfba_pkg::top_t'(1);
        end
      end

      gfba_pkg::ST_SPILL: begin
        // rd_value holds slot idx_r; prefetch the next slot
        req.rd_idx      = idx_r + gfba_pkg::slot_t'(1);
        out_valid_nxt   = 1'b1;
        out_kind_nxt    = gfba_pkg::K_SPILL;
        out_address_nxt = spill_addr_r;
        out_sidx_nxt    = gfba_pkg::eidx_t'(idx_r);
        out_sval_nxt    = rd_value;
        out_last_nxt    = (idx_r == gfba_pkg::SLOT_LAST);
        if (idx_r == gfba_pkg::SLOT_LAST) begin
          state_nxt   = gfba_pkg::ST_IDLE;
          req.clear   = 1'b1;
          req.wr_en   = 1'b1;
          req.wr_idx  = '0;
          req.wr_data = spill_addr_r;
          top_nxt     = '0;
        end else begin
          idx_nxt = idx_r + gfba_pkg::slot_t'(1);
        end
      end

      default: begin
        state_nxt = gfba_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy              = (state_r != gfba_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_address       = out_address_r;
  assign out_spill_index   = out_sidx_r;
  assign out_spill_value   = out_sval_r;
  assign out_refill_needed = out_refill_r;
  assign out_last          = out_last_r;

`ifndef SYNTH
  // every accepted word answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted word produced neither result nor busy");

  // a spill run is still going until its last word
  a_spill_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == gfba_pkg::K_SPILL) && !out_last) |-> busy)
    else $error("spill run left busy early");

  // while waiting for a refill the group is empty
  a_refill_empty: assert property (@(posedge clk) disable iff (!rst_n)
    awaiting_r |-> (top_r == gfba_pkg::TOP_EMPTY))
    else $error("refill pending with nonempty group");

  // the top pointer never leaves the group
  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    (top_r >= gfba_pkg::TOP_EMPTY) && (top_r <= gfba_pkg::TOP_MAX))
    else $error("stack top out of range");
`endif

endmodule
`default_nettype wire
